>>> hdl/pion_out_side_histogram_assert.svh
// Assertion macros shared by the histogram RTL.
`ifndef PION_OUT_SIDE_HISTOGRAM_ASSERT_SVH
`define PION_OUT_SIDE_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define POHIST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define POHIST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

>>> hdl/pohist_pkg.sv
// Package: sizes, codes and helper functions of the out/side histogram.
`default_nettype none
package pohist_pkg;

    localparam int BINS   = 150;
    localparam int CELLS  = BINS * BINS;
    localparam int BIN_W  = $clog2(BINS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam int IN_DATA_W  = 280;
    localparam int OUT_DATA_W = 120;
    localparam int CFG_IDX_W  = 3;

    // Register reset values
    localparam logic [30:0]        PION_CODE_RST = 31'd211;
    localparam logic [31:0]        PT_MIN_RST    = 32'd7864;
    localparam logic [31:0]        PT_MAX_RST    = 32'd10486;
    localparam logic signed [31:0] AXIS_LOW_RST  = -32'sd1638400;
    localparam logic signed [31:0] AXIS_HIGH_RST = 32'sd1638400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PION_CODE = 3'd0,
        CFG_PT_MIN    = 3'd1,
        CFG_PT_MAX    = 3'd2,
        CFG_AXIS_LOW  = 3'd3,
        CFG_AXIS_HIGH = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STORE_PRIM  = 2'd0,
        STORE_RES   = 2'd1,
        STORE_TOTAL = 2'd2
    } t_store;

    typedef enum logic [1:0] {
        DSEL_OUT   = 2'd0,
        DSEL_SIDE  = 2'd1,
        DSEL_BIN_S = 2'd2,
        DSEL_BIN_O = 2'd3
    } t_dsel;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CUT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RANGE,
        ST_ADDR,
        ST_RD,
        ST_WB,
        ST_DONE
    } t_state;

    // Saturate a sign and magnitude quotient to signed 32 bits
    function automatic logic signed [31:0] sat_quo(input logic neg, input logic [63:0] quo);
        logic signed [31:0] res;
        if (neg) begin
            if (quo >= 64'h8000_0000) res = 32'sh8000_0000;
            else                      res = 32'(-quo);
        end else begin
            if (quo > 64'h7FFF_FFFF)  res = 32'sh7FFF_FFFF;
            else                      res = 32'(quo);
        end
        return res;
    endfunction

    // Saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage
`default_nettype wire

>>> hdl/pohist_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module pohist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/pohist_isqrt.sv
// Iterative 64-bit integer square root, one result bit per cycle.
`default_nettype none
module pohist_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output      logic        o_done,
    output      logic [31:0] o_root
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [63:0] r_n;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial  = r_res + r_bit;
    assign o_root = r_res[31:0];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Digit-by-digit root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_val;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end
endmodule
`default_nettype wire

>>> hdl/pohist_divu.sv
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module pohist_divu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output      logic        o_busy,
    output      logic        o_done,
    output      logic [63:0] o_quo
);
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted = {r_rem, r_num[63]};
    assign diff    = shifted - {1'b0, r_den};
    assign o_quo   = r_num;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                o_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (o_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    o_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Shift-subtract step; quotient bits fill the numerator register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (o_busy) begin
            if (!diff[64]) begin
                r_rem <= diff[63:0];
                r_num <= {r_num[62:0], 1'b1};
            end else begin
                r_rem <= shifted[63:0];
                r_num <= {r_num[62:0], 1'b0};
            end
        end
    end

    `include "pion_out_side_histogram_assert.svh"
    `POHIST_ASSERT_IMP(a_div_no_restart, i_start, !o_busy)
    `POHIST_ASSERT_NXT(a_div_busy_after_start, i_start, o_busy)
    `POHIST_ASSERT_IMP(a_div_done_not_busy, o_done, !o_busy)
endmodule
`default_nettype wire

>>> hdl/pion_out_side_histogram.sv
// Top level: pion out/side emission histogram with cut logic and count stores.
//
// Each slave-side transaction is one fill (a particle) or one read (a bin).
// After reset the block zeroes both count stores, one entry per cycle, all
// 22500 entries (BINS*BINS), with tready low; configuration writes are taken
// throughout. A fill that passes the id and energy cut forms its products
// one per cycle from a single 33x33 multiplier, then meets the pt cut; past
// it, the square root and up to four divisions (out, side, two bin indices)
// run one after another through one shared bit-serial divider; the bin
// divisions follow only if both values lie in the axis range. One item is
// in work at a time; a new item is taken while the last result still waits
// in the master-side output register.
`default_nettype none
module pion_out_side_histogram (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Slave side
    input  wire logic                            i_s_axis_tvalid,
    output      logic                            o_s_axis_tready,
    // tdata, from bit 0: particle_id, parent_id, energy, mom_x, mom_y, mom_z,
    // pos_x, pos_y, read_store, read_side_bin, read_out_bin, zero fill
    input  wire logic [pohist_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: mode
    input  wire logic                            i_s_axis_tuser,
    // Master side
    output      logic                            o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // tdata, from bit 0: accepted, is_primordial, side_value, out_value,
    // side_index, out_index, bin_count, zero fill
    output      logic [pohist_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // Configuration write channel
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [pohist_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data
);
    import pohist_pkg::*;

    // Configuration registers
    logic [30:0]        r_pion_code;
    logic [31:0]        r_pt_min;
    logic [31:0]        r_pt_max;
    logic signed [31:0] r_axis_low;
    logic signed [31:0] r_axis_high;

    // Control
    t_state            r_state, n_state;
    t_dsel             r_dsel;
    logic [2:0]        r_step;
    logic [ADDR_W-1:0] r_addr;
    logic              r_mode;
    logic [1:0]        r_store;
    logic              r_rd_ok;
    logic              r_idok;

    // Datapath
    logic signed [31:0] r_px, r_py, r_x, r_y;
    logic [63:0]        r_prod [8];
    logic [63:0]        r_s;
    logic signed [64:0] r_onum, r_snum;
    logic [31:0]        r_q;
    logic [63:0]        r_bnum_s, r_bnum_o, r_span;

    // Result fields
    logic               r_acc, r_prim;
    logic signed [31:0] r_sidev, r_outv;
    logic [BIN_W-1:0]   r_sidx, r_oidx;
    logic [31:0]        r_cnt;

    // Input unpacking
    logic signed [31:0] in_pid, in_par, in_e, in_pz;
    logic [1:0]         in_store;
    logic [7:0]         in_sbin, in_obin;
    logic signed [32:0] pid33, pc33;
    logic               s_acc;

    assign in_pid   = i_s_axis_tdata[31:0];
    assign in_par   = i_s_axis_tdata[63:32];
    assign in_e     = i_s_axis_tdata[95:64];
    assign in_pz    = i_s_axis_tdata[191:160];
    assign in_store = i_s_axis_tdata[257:256];
    assign in_sbin  = i_s_axis_tdata[265:258];
    assign in_obin  = i_s_axis_tdata[273:266];
    assign pid33    = {in_pid[31], in_pid};
    assign pc33     = {2'b00, r_pion_code};

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pion_code <= PION_CODE_RST;
            r_pt_min    <= PT_MIN_RST;
            r_pt_max    <= PT_MAX_RST;
            r_axis_low  <= AXIS_LOW_RST;
            r_axis_high <= AXIS_HIGH_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PION_CODE: r_pion_code <= i_cfg_data[30:0];
                CFG_PT_MIN:    r_pt_min    <= i_cfg_data;
                CFG_PT_MAX:    r_pt_max    <= i_cfg_data;
                CFG_AXIS_LOW:  r_axis_low  <= i_cfg_data;
                CFG_AXIS_HIGH: r_axis_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Shared multiplier, operands chosen by step
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    always_comb begin
        case (r_step)
            3'd0:    begin mul_a = 33'(r_px); mul_b = 33'(r_px); end
            3'd1:    begin mul_a = 33'(r_py); mul_b = 33'(r_py); end
            3'd2:    begin mul_a = {1'b0, r_pt_min}; mul_b = {1'b0, r_pt_min}; end
            3'd3:    begin mul_a = {1'b0, r_pt_max}; mul_b = {1'b0, r_pt_max}; end
            3'd4:    begin mul_a = 33'(r_x); mul_b = 33'(r_px); end
            3'd5:    begin mul_a = 33'(r_y); mul_b = 33'(r_py); end
            3'd6:    begin mul_a = 33'(r_x); mul_b = 33'(r_py); end
            default: begin mul_a = 33'(r_y); mul_b = 33'(r_px); end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Square root and divider
    logic        sq_done;
    logic [31:0] sq_root;
    logic        div_start, div_busy, div_done;
    logic [63:0] div_num, div_den, div_quo;
    logic        div_neg;

    pohist_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_SQ_GO),
        .i_val   (r_s),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_comb begin
        case (r_dsel)
            DSEL_OUT: begin
                div_neg = r_onum[64];
                div_num = r_onum[64] ? 64'(-r_onum) : r_onum[63:0];
                div_den = 64'(r_q);
            end
            DSEL_SIDE: begin
                div_neg = r_snum[64];
                div_num = r_snum[64] ? 64'(-r_snum) : r_snum[63:0];
                div_den = 64'(r_q);
            end
            DSEL_BIN_S: begin
                div_neg = 1'b0;
                div_num = r_bnum_s;
                div_den = r_span;
            end
            default: begin
                div_neg = 1'b0;
                div_num = r_bnum_o;
                div_den = r_span;
            end
        endcase
    end

    assign div_start = (r_state == ST_DIV_GO);

    pohist_divu u_divu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Axis range check and bin numerators
    logic signed [32:0] span33, sd33, od33;
    logic               in_range;

    assign span33   = 33'(r_axis_high) - 33'(r_axis_low);
    assign sd33     = 33'(r_sidev) - 33'(r_axis_low);
    assign od33     = 33'(r_outv) - 33'(r_axis_low);
    assign in_range = (span33 > 33'sd0)
                   && (r_sidev >= r_axis_low) && (r_sidev < r_axis_high)
                   && (r_outv >= r_axis_low) && (r_outv < r_axis_high);

    // Count stores
    logic [31:0] prim_rd, res_rd, inc_val, wr_data;
    logic        we_prim, we_res, clearing;

    assign clearing = (r_state == ST_CLEAR);
    assign inc_val  = sat_add(r_prim ? prim_rd : res_rd, 32'd1);
    assign wr_data  = clearing ? 32'd0 : inc_val;
    assign we_prim  = clearing || ((r_state == ST_WB) && !r_mode && r_prim);
    assign we_res   = clearing || ((r_state == ST_WB) && !r_mode && !r_prim);

    pohist_ram #(.WIDTH(32), .DEPTH(CELLS)) u_prim_ram (
        .i_clk   (i_clk),
        .i_we    (we_prim),
        .i_waddr (r_addr),
        .i_wdata (wr_data),
        .i_raddr (r_addr),
        .o_rdata (prim_rd)
    );

    pohist_ram #(.WIDTH(32), .DEPTH(CELLS)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (we_res),
        .i_waddr (r_addr),
        .i_wdata (wr_data),
        .i_raddr (r_addr),
        .o_rdata (res_rd)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr == ADDR_W'(CELLS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_axis_tuser) n_state = ST_RD;
                    else if ((pid33 == pc33 || pid33 == -pc33) && in_e != in_pz)
                        n_state = ST_MUL;
                    else n_state = ST_DONE;
                end
            end
            ST_MUL:      if (r_step == 3'd7) n_state = ST_SUM;
            ST_SUM:      n_state = ST_CUT;
            ST_CUT: begin
                if (r_s > r_prod[2] && r_s < r_prod[3]) n_state = ST_SQ_GO;
                else n_state = ST_DONE;
            end
            ST_SQ_GO:    n_state = ST_SQ_WAIT;
            ST_SQ_WAIT: begin
                if (sq_done) n_state = (sq_root == 32'd0) ? ST_DONE : ST_DIV_GO;
            end
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    case (r_dsel)
                        DSEL_SIDE:  n_state = ST_RANGE;
                        DSEL_BIN_O: n_state = ST_ADDR;
                        default:    n_state = ST_DIV_GO;
                    endcase
                end
            end
            ST_RANGE:    n_state = in_range ? ST_DIV_GO : ST_DONE;
            ST_ADDR:     n_state = ST_RD;
            ST_RD:       n_state = ST_WB;
            ST_WB:       n_state = ST_DONE;
            ST_DONE: begin
                if (!o_m_axis_tvalid || i_m_axis_tready) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLEAR;
        else          r_state <= n_state;
    end

    // Address counter: clearing sweep, then the bin under access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (clearing) begin
            r_addr <= r_addr + ADDR_W'(1);
        end else if (s_acc) begin
            r_addr <= ADDR_W'(in_sbin) * ADDR_W'(BINS) + ADDR_W'(in_obin);
        end else if (r_state == ST_ADDR) begin
            r_addr <= ADDR_W'(r_sidx) * ADDR_W'(BINS) + ADDR_W'(r_oidx);
        end
    end

    // Datapath sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_dsel <= DSEL_OUT;
        end else begin
            if (s_acc) r_step <= '0;
            else if (r_state == ST_MUL) r_step <= r_step + 3'd1;
            if (r_state == ST_SQ_WAIT) r_dsel <= DSEL_OUT;
            if (r_state == ST_DIV_WAIT && div_done) begin
                case (r_dsel)
                    DSEL_OUT:   r_dsel <= DSEL_SIDE;
                    DSEL_SIDE:  r_dsel <= DSEL_BIN_S;
                    DSEL_BIN_S: r_dsel <= DSEL_BIN_O;
                    default:    r_dsel <= DSEL_OUT;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mode   <= i_s_axis_tuser;
            r_store  <= in_store;
            r_rd_ok  <= (32'(in_sbin) < 32'(BINS)) && (32'(in_obin) < 32'(BINS));
            r_idok   <= (pid33 == pc33) || (pid33 == -pc33);
            r_px     <= i_s_axis_tdata[127:96];
            r_py     <= i_s_axis_tdata[159:128];
            r_x      <= i_s_axis_tdata[223:192];
            r_y      <= i_s_axis_tdata[255:224];
            r_acc    <= 1'b0;
            r_prim   <= !i_s_axis_tuser && (in_pid == in_par);
            r_sidev  <= '0;
            r_outv   <= '0;
            r_sidx   <= '0;
            r_oidx   <= '0;
            r_cnt    <= '0;
        end
        if (r_state == ST_MUL) r_prod[r_step] <= mul_p[63:0];
        if (r_state == ST_SUM) begin
            r_s    <= r_prod[0] + r_prod[1];
            r_onum <= 65'($signed(r_prod[4])) + 65'($signed(r_prod[5]));
            r_snum <= 65'($signed(r_prod[6])) - 65'($signed(r_prod[7]));
        end
        if (r_state == ST_SQ_WAIT && sq_done) r_q <= sq_root;
        if (r_state == ST_DIV_WAIT && div_done) begin
            case (r_dsel)
                DSEL_OUT:   r_outv  <= sat_quo(div_neg, div_quo);
                DSEL_SIDE:  r_sidev <= sat_quo(div_neg, div_quo);
                DSEL_BIN_S: r_sidx  <= div_quo[BIN_W-1:0];
                default:    r_oidx  <= div_quo[BIN_W-1:0];
            endcase
        end
        if (r_state == ST_RANGE) begin
            r_bnum_s <= 64'(sd33[32:0]) * 64'(BINS);
            r_bnum_o <= 64'(od33[32:0]) * 64'(BINS);
            r_span   <= 64'(span33[32:0]);
            if (!in_range) begin
                r_sidx <= '0;
                r_oidx <= '0;
            end
        end
        if (r_state == ST_WB) begin
            if (!r_mode) begin
                r_acc <= 1'b1;
            end else if (r_rd_ok) begin
                case (t_store'(r_store))
                    STORE_PRIM:  r_cnt <= prim_rd;
                    STORE_RES:   r_cnt <= res_rd;
                    STORE_TOTAL: r_cnt <= sat_add(prim_rd, res_rd);
                    default:     r_cnt <= '0;
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_axis_tvalid <= 1'b0;
        end else if (r_state == ST_DONE && (!o_m_axis_tvalid || i_m_axis_tready)) begin
            o_m_axis_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            o_m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!o_m_axis_tvalid || i_m_axis_tready)) begin
            o_m_axis_tdata <= {6'd0, r_cnt, 8'(r_oidx), 8'(r_sidx), r_outv, r_sidev,
                               r_prim, r_acc};
        end
    end

    `include "pion_out_side_histogram_assert.svh"
    `POHIST_ASSERT_IMP(a_no_accept_while_clearing, clearing, !o_s_axis_tready)
    `POHIST_ASSERT_IMP(a_store_write_states, we_prim || we_res,
        r_state == ST_CLEAR || r_state == ST_WB)
    `POHIST_ASSERT_IMP(a_fill_bin_in_range, r_state == ST_WB && !r_mode,
        r_idok && ({1'b0, r_sidx} < (BIN_W + 1)'(BINS)) && ({1'b0, r_oidx} < (BIN_W + 1)'(BINS)))
    `POHIST_ASSERT_NXT(a_single_store_write, r_state == ST_WB, r_state == ST_DONE)
endmodule
`default_nettype wire
